// ===== sv/idwl_pkg.sv =====
// ----------------------------------------------------------------------------
// idwl_pkg
// Shared types, action codes and constants for the card identifier whitelist.
// ----------------------------------------------------------------------------
`default_nettype none

package idwl_pkg;

   // Default table depth; the top level may override it.
   localparam int unsigned MaxEntriesDefault = 16;

   // Field widths fixed by the request and response formats.
   localparam int unsigned IdWidth       = 32;
   localparam int unsigned ActionWidth   = 2;
   localparam int unsigned CountOutWidth = 5;

   // Number of leading identifier bytes that take part in a comparison.
   localparam int unsigned IdBytes  = 4;
   localparam int unsigned KeyBytes = (IdBytes > 4) ? 4 : IdBytes;
   localparam logic [IdWidth-1:0] KeyMask =
      (KeyBytes == 0) ? '0 : (32'hFFFF_FFFF << (8 * (4 - KeyBytes)));

   // Action codes. The unused code behaves as a lookup.
   localparam logic [ActionWidth-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ActionWidth-1:0] ACT_ADD    = 2'd1;
   localparam logic [ActionWidth-1:0] ACT_DELETE = 2'd2;

   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [IdWidth-1:0]     card_id;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic                     applied;
      logic                     table_full;
      logic [CountOutWidth-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_ADD,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture a new request and restart the walk
      logic scan;     // walk step of the search
      logic shift;    // walk step of the delete compaction
      logic add;      // append or refuse the identifier
      logic del;      // commit the delete
      logic finish;   // move the result into the response register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;      // the entry under comparison matches
      logic drained;  // no read pending and no entry left to read
      logic is_add;
      logic is_del;
      logic rsp_free; // response register can take a new result
   } dp_stat_type;

endpackage : idwl_pkg

`default_nettype wire

// ===== sv/id_whitelist_table_core.sv =====
// ----------------------------------------------------------------------------
// id_whitelist_table_core
// Dense whitelist of card identifiers with lookup, add-if-absent and
// delete-with-compaction, one response per request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid / req_stall  req_data  (action, card_id)
//   rsp_      out         rsp_valid / rsp_stall  rsp_data  (found, applied,
//                                                           table_full,
//                                                           entry_count)
//
// An accepted request walks the RAM (one entry per cycle) in search, and then in
// compaction after a delete hit, or tries an append after an add miss.
// Reset is synchronous and active high; it zeroes the fill count and drops any
// pending response, but leaves the RAM contents as they are.
// The response register lets a new request be accepted while the previous
// response is stalled; a stalled response only holds up the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module id_whitelist_table_core
   import idwl_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // Request channel.
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // Response channel.
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // The controller sequences each request through search, optional
   // compaction or append, and result; the datapath holds all storage.
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        idle;

   idwl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   idwl_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A new request is taken only while the sequencer is waiting for one.
   assign req_stall = !idle;

endmodule : id_whitelist_table_core

`default_nettype wire

// ===== sv/idwl_ram.sv =====
// ----------------------------------------------------------------------------
// idwl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module idwl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : idwl_ram

`default_nettype wire

// ===== sv/idwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// idwl_ctrl
// Sequencer for the whitelist: search walk, compaction walk, append, result.
// ----------------------------------------------------------------------------
`default_nettype none

module idwl_ctrl
   import idwl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd,
   output logic             idle
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = stat.is_del ? ST_SHIFT : ST_DONE;
            end else if (stat.drained) begin
               state_in = stat.is_add ? ST_ADD : ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (stat.drained) begin
               state_in = ST_DONE;
            end
         end
         ST_ADD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle     = 1'b1;
            cmd.load = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            cmd.del   = stat.drained;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule : idwl_ctrl

`default_nettype wire

// ===== sv/idwl_dp.sv =====
// ----------------------------------------------------------------------------
// idwl_dp
// Datapath: request registers, fill count, identifier RAM, walk pointer,
// compare logic and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module idwl_dp
   import idwl_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire req_type     req_data,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ENTRIES);

   logic [ActionWidth-1:0] act_ff;
   logic [ActionWidth-1:0] act_in;
   logic [IdWidth-1:0]     id_ff;
   logic [IdWidth-1:0]     id_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [CNT_W-1:0]       rd_idx_ff;
   logic [CNT_W-1:0]       rd_idx_in;
   logic                   pend_ff;
   logic                   pend_in;
   logic                   found_ff;
   logic                   found_in;
   logic                   applied_ff;
   logic                   applied_in;
   logic                   full_ff;
   logic                   full_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [IdWidth-1:0]     rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [IdWidth-1:0]     wr_data;
   logic [CNT_W-1:0]       shift_dst;
   logic                   issue;
   logic                   match;
   logic                   room;
   logic [CNT_W+CountOutWidth-1:0] cnt_ext;

   idwl_ram #(
      .WIDTH (IdWidth),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // A read is issued at the walk pointer while it is below the fill count;
   // its data arrives in the next cycle, flagged by pend_ff.
   assign issue     = (cmd.scan || cmd.shift) && (rd_idx_ff < cnt_ff);
   assign match     = ((rd_data ^ id_ff) & KeyMask) == '0;
   assign room      = cnt_ff < MaxCnt;
   // During compaction the entry read at pointer minus one moves down one place.
   assign shift_dst = rd_idx_ff - CNT_W'(2);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = shift_dst[AW-1:0];
      wr_data = rd_data;
      if (cmd.shift && pend_ff) begin
         wr_en = 1'b1;
      end else if (cmd.add && !found_ff && room) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[AW-1:0];
         wr_data = id_ff;
      end
   end

   assign stat.hit      = pend_ff && match;
   assign stat.drained  = !pend_ff && (rd_idx_ff >= cnt_ff);
   assign stat.is_add   = act_ff == ACT_ADD;
   assign stat.is_del   = act_ff == ACT_DELETE;
   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign cnt_ext = {{CountOutWidth{1'b0}}, cnt_ff};

   always_comb begin
      act_in     = act_ff;
      id_in      = id_ff;
      cnt_in     = cnt_ff;
      rd_idx_in  = rd_idx_ff;
      pend_in    = 1'b0;
      found_in   = found_ff;
      applied_in = applied_ff;
      full_in    = full_ff;
      if (cmd.load) begin
         act_in     = req_data.action;
         id_in      = req_data.card_id;
         rd_idx_in  = '0;
         found_in   = 1'b0;
         applied_in = 1'b0;
         full_in    = 1'b0;
      end
      if (issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
         pend_in   = 1'b1;
      end
      if (cmd.scan && pend_ff && match) begin
         found_in = 1'b1;
      end
      if (cmd.add) begin
         if (room) begin
            cnt_in     = cnt_ff + CNT_W'(1);
            applied_in = 1'b1;
         end else begin
            full_in = 1'b1;
         end
      end
      if (cmd.del) begin
         cnt_in     = cnt_ff - CNT_W'(1);
         applied_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in       = 1'b1;
         rsp_in.found       = found_ff;
         rsp_in.applied     = applied_ff;
         rsp_in.table_full  = full_ff;
         rsp_in.entry_count = cnt_ext[CountOutWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      id_ff      <= id_in;
      rd_idx_ff  <= rd_idx_in;
      found_ff   <= found_in;
      applied_ff <= applied_in;
      full_ff    <= full_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : idwl_dp

`default_nettype wire

// ===== sv/idwl_checker.sv =====
// ----------------------------------------------------------------------------
// idwl_checker
// Port-level checks for the whitelist core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module idwl_checker
   import idwl_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // After reset the block is ready for a request and has no response.
   assert property (@(posedge clock) reset |=> !req_stall && !rsp_valid)
      else $error("idwl: not idle after reset");

   // An accepted request always stalls the request side; no request is finished as it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("idwl: accepted a request while still busy");

   // A stalled response stays and holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("idwl: stalled response changed");

   // A refused add never reports a change or a present identifier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |-> !rsp_data.applied && !rsp_data.found)
      else $error("idwl: inconsistent response flags");

endmodule : idwl_checker

bind id_whitelist_table_core idwl_checker u_idwl_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the card identifier whitelist core.
// A directed walk through the corner cases of lookup, add and delete comes
// first. Several hundred random requests follow, which push the table from
// empty to full and back. Every response is compared field by field against
// the answer written in a directed row or a behavioral whitelist kept
// inside the bench; the sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------

module tb;
   import idwl_pkg::*;

   localparam int unsigned DEPTH        = MaxEntriesDefault;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned HOLD_CYCLES  = 300;
   // The slowest request walks the whole table; allow some slack.
   localparam int unsigned DRAIN_CYCLES = DEPTH + 30;
   localparam int unsigned POOL_SIZE    = 24;

   // The fourth action code has no name in the package; the core treats it
   // as a lookup.
   localparam logic [ActionWidth-1:0] ACT_SPARE = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   id_whitelist_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Behavioral whitelist. It holds the same dense list and fill count as the
   // core and is advanced once for every request that the core accepts.
   // -------------------------------------------------------------------------
   logic [IdWidth-1:0] model_ids [DEPTH];
   int unsigned        model_count;
   int unsigned        peak_count;

   // Answers still owed by the core, oldest first.
   rsp_type awaited_answers [$];

   int unsigned mismatches;
   int unsigned requests_sent;
   int unsigned answers_checked;
   int unsigned refused_adds;
   int unsigned changes_made;

   // Receiver hold-off handshake between the sender and the stall process.
   bit backpressure_req;
   bit backpressure_active;
   bit backpressure_done;
   int unsigned sender_quiet;

   // Applies one request to the behavioral whitelist and returns the answer
   // the core must give for it.
   function automatic rsp_type whitelist_apply(input req_type item);
      rsp_type     answer;
      int unsigned slot;
      int unsigned j;
      answer = '0;
      slot   = DEPTH;
      // Only the first match below the fill count matters.
      for (j = 0; j < model_count; j++) begin
         if (slot == DEPTH && ((model_ids[j] ^ item.card_id) & KeyMask) == '0) begin
            slot = j;
         end
      end
      answer.found = (slot < DEPTH);
      case (item.action)
         ACT_ADD: begin
            if (!answer.found) begin
               if (model_count < DEPTH) begin
                  model_ids[model_count] = item.card_id;
                  model_count++;
                  answer.applied = 1'b1;
               end else begin
                  answer.table_full = 1'b1;
               end
            end
         end
         ACT_DELETE: begin
            if (answer.found) begin
               // Close the gap so that the list stays dense.
               for (j = slot; j + 1 < model_count; j++) begin
                  model_ids[j] = model_ids[j + 1];
               end
               model_count--;
               answer.applied = 1'b1;
            end
         end
         default: begin
            // Lookup, and the spare code that behaves as one.
         end
      endcase
      answer.entry_count = CountOutWidth'(model_count);
      if (model_count > peak_count) begin
         peak_count = model_count;
      end
      return answer;
   endfunction

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Clock and reset. Reset is held from the start and released on a falling
   // edge so that the first request sees a clean, idle core.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin
      #10_000_000;
      $display("Run stopped by the watchdog with %0d answers outstanding.",
               awaited_answers.size());
      $display("Verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sender. Each request is driven on a falling edge and held unchanged until
   // a rising edge sees valid high with stall low. The whitelist is advanced
   // at that same edge, so the expectation is queued in acceptance order.
   // -------------------------------------------------------------------------
   task automatic send_request(input req_type item, input bit typed,
                               input rsp_type typed_answer);
      int unsigned gap;
      rsp_type     predicted;
      gap = idle_len();
      if (sender_quiet > 0) begin
         gap = 0;
         sender_quiet--;
      end else if ($urandom_range(0, 19) == 0) begin
         sender_quiet = $urandom_range(20, 60);
      end
      // Keep offering requests back to back while the receiver holds off.
      if (backpressure_active) begin
         gap = 0;
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = whitelist_apply(item);
      // Where the answer is written into the directed list it takes
      // precedence; the whitelist is still advanced so that it stays in step.
      awaited_answers.push_back(typed ? typed_answer : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // One row of the directed list.
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type answer;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void dir_row(input logic [ActionWidth-1:0] act,
                                   input logic [IdWidth-1:0] id, input bit typed,
                                   input logic f, input logic ap, input logic fu,
                                   input int unsigned cnt);
      dir_row_type row;
      row.item.action        = act;
      row.item.card_id       = id;
      row.typed              = typed;
      row.answer.found       = f;
      row.answer.applied     = ap;
      row.answer.table_full  = fu;
      row.answer.entry_count = CountOutWidth'(cnt);
      dir_rows.push_back(row);
   endfunction

   initial begin
      logic [IdWidth-1:0] pool [POOL_SIZE];
      req_type            item;
      rsp_type            unused_answer;
      int unsigned        k;
      int unsigned        r;
      int unsigned        phase_left;
      bit                 filling;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      model_count = 0;
      peak_count  = 0;
      mismatches  = 0;
      requests_sent   = 0;
      answers_checked = 0;
      refused_adds    = 0;
      changes_made    = 0;
      backpressure_req    = 1'b0;
      backpressure_active = 1'b0;
      backpressure_done   = 1'b0;
      sender_quiet        = 0;
      unused_answer       = '0;

      // A lookup and a delete on an empty table.
      dir_row(ACT_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 0);
      dir_row(ACT_DELETE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 0);
      // The two extreme identifiers, a duplicate add, and the spare code on
      // a present identifier.
      dir_row(ACT_ADD,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1);
      dir_row(ACT_ADD,    32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 2);
      dir_row(ACT_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 2);
      dir_row(ACT_SPARE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 2);
      // A near miss in the lowest bit must not match.
      dir_row(ACT_LOOKUP, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, 1'b0, 2);
      // Deleting the first entry shifts the other one down.
      dir_row(ACT_DELETE, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1);
      // Fill the table to the brim.
      for (k = 0; k < DEPTH - 1; k++) begin
         dir_row(ACT_ADD, 32'hA5A5_0000 + k * 32'h0101_0001, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      end
      // A full table refuses a new identifier but not a present one.
      dir_row(ACT_ADD,    32'h1234_5678, 1'b1, 1'b0, 1'b0, 1'b1, DEPTH);
      dir_row(ACT_ADD,    32'hA5A5_0000, 1'b1, 1'b1, 1'b0, 1'b0, DEPTH);
      // Delete from the middle of a full list, then from the end of the list.
      dir_row(ACT_DELETE, 32'hA5A5_0000 + 7 * 32'h0101_0001, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      dir_row(ACT_DELETE, 32'hA5A5_0000 + 14 * 32'h0101_0001, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      dir_row(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 0);

      // A small identifier pool keeps hits and a full table frequent. Some
      // entries differ from their neighbor in a single bit.
      for (k = 0; k < POOL_SIZE; k++) begin
         if (k % 3 == 0) begin
            pool[k] = $urandom;
         end else begin
            pool[k] = pool[k - 1] ^ (32'h1 << $urandom_range(0, 31));
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].answer);
      end

      // Random part: alternating fill and drain phases with random content.
      filling    = 1'b1;
      phase_left = 0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (phase_left == 0) begin
            filling    = ~filling;
            phase_left = $urandom_range(30, 90);
         end
         phase_left--;
         if (k == 150) begin
            backpressure_req = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 10) begin
            item.action = ACT_SPARE;
         end else if (r < 35) begin
            item.action = ACT_LOOKUP;
         end else if (r < (filling ? 85 : 50)) begin
            item.action = ACT_ADD;
         end else begin
            item.action = ACT_DELETE;
         end
         r = $urandom_range(0, 99);
         if (r < 40 && model_count > 0) begin
            item.card_id = model_ids[$urandom_range(0, model_count - 1)];
         end else if (r < 85) begin
            item.card_id = pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            item.card_id = $urandom;
         end
         send_request(item, 1'b0, unused_answer);
      end
      req_valid = 1'b0;

      // Wait for every owed answer, then give the core time to show anything
      // it should not send.
      while (awaited_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d answers: %0d table changes,",
               requests_sent, answers_checked, changes_made);
      $display("%0d adds refused on a full table, peak fill %0d of %0d, %0d mismatches.",
               refused_adds, peak_count, DEPTH, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver stall. Random stall and free stretches, with one long hold-off
   // once the sender asks for it; the core must then fill up and stall its
   // request side.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (backpressure_req && !backpressure_done) begin
            backpressure_active = 1'b1;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            backpressure_active = 1'b0;
            backpressure_done   = 1'b1;
         end
         n = idle_len();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
         repeat (n) @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Answer checking on every accepted response.
   // -------------------------------------------------------------------------
   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   rsp_type owed;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t ns: response with none expected, expected nothing, actual %p",
                     $time, rsp_data);
            mismatches++;
         end else begin
            owed = awaited_answers.pop_front();
            compare_field("found",       owed.found,       rsp_data.found);
            compare_field("applied",     owed.applied,     rsp_data.applied);
            compare_field("table_full",  owed.table_full,  rsp_data.table_full);
            compare_field("entry_count", owed.entry_count, rsp_data.entry_count);
            answers_checked++;
            refused_adds += rsp_data.table_full;
            changes_made += rsp_data.applied;
         end
      end
   end

endmodule

// ===== sim.f =====
sv/idwl_pkg.sv
sv/idwl_ram.sv
sv/idwl_ctrl.sv
sv/idwl_dp.sv
sv/id_whitelist_table_core.sv
sv/idwl_checker.sv
bench/tb.sv
